/* hw/rtl/pfsd_pkg.sv */
package pfsd_pkg;

   // number format
   localparam int FRAC_BITS = 16;
   localparam int W = 32;
   localparam int WW = W + 4;

   // pipeline shape
   localparam int SQRT_STEPS = 32;
   localparam int NUM_W = W + FRAC_BITS;
   localparam int DIV_STEPS = NUM_W;
   localparam int TERM_STAGES = 7;
   localparam int N_STG = 1 + SQRT_STEPS + 1 + DIV_STEPS + TERM_STAGES;
   localparam int ST_PREP = 1 + SQRT_STEPS;

   // divider lanes
   localparam int NUM_LANES = 7;
   localparam int LANE_CX = 0;
   localparam int LANE_CY = 1;
   localparam int LANE_ZR = 2;
   localparam int LANE_IR = 3;
   localparam int LANE_IRZ = 4;
   localparam int LANE_RR = 5;
   localparam int LANE_FAC = 6;

   // constants
   localparam logic [W-1:0] ONE_QF = W'(longint'(1) << FRAC_BITS);
   localparam longint INV4PI_Q32 = 341782638;
   localparam logic [W-1:0] INV4PI_QF =
      W'((INV4PI_Q32 + (longint'(1) << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
   localparam logic [30:0] SHEAR_RESET = 31'd65536;
   localparam logic [15:0] POISSON_RESET = 16'd19661;

   // register map
   localparam int CSR_AW = 3;
   localparam logic CSR_IDX_SHEAR = 1'b0;
   localparam logic CSR_IDX_POISSON = 1'b1;

   typedef logic signed [W-1:0] q_type;
   typedef logic signed [WW-1:0] wq_type;

   typedef struct packed {
      q_type pos_x;
      q_type pos_y;
      q_type pos_z;
      q_type normal_force;
      q_type shear_force_x;
      q_type shear_force_y;
      q_type disp_x_in;
      q_type disp_y_in;
      q_type disp_z_in;
   } sq_side_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
      sq_side_type side;
   } sq_pl_type;

   typedef struct packed {
      q_type normal_force;
      q_type shear_force_x;
      q_type shear_force_y;
      q_type disp_x_in;
      q_type disp_y_in;
      q_type disp_z_in;
      logic singular;
   } dv_side_type;

   typedef struct packed {
      logic [W-1:0] rem;
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] quo;
      logic [W-1:0] dvs;
      logic neg;
   } dv_lane_type;

   typedef struct packed {
      dv_lane_type [NUM_LANES-1:0] lane;
      dv_side_type side;
   } dv_pl_type;

   typedef struct packed {
      q_type disp_x_out;
      q_type disp_y_out;
      q_type disp_z_out;
      logic singular;
   } rsp_pl_type;

   function automatic logic [W-1:0] mag(q_type v);
      return v[W-1] ? W'(-v) : W'(v);
   endfunction

   // magnitude and sign to saturated signed value
   function automatic q_type mag_to_q(logic [63:0] m, logic neg);
      if (neg) begin
         if (m >= 64'h8000_0000) return q_type'(32'h8000_0000);
         else return q_type'(-m[W-1:0]);
      end else begin
         if (m >= 64'h8000_0000) return q_type'(32'h7fff_ffff);
         else return q_type'(m[W-1:0]);
      end
   endfunction

   function automatic q_type sat32(wq_type v);
      if (v > wq_type'(32'sh7fff_ffff)) return q_type'(32'h7fff_ffff);
      else if (v < wq_type'(32'sh8000_0000)) return q_type'(32'h8000_0000);
      else return q_type'(v[W-1:0]);
   endfunction

   // fixed point product, rounded half away from zero
   function automatic q_type qmul(q_type a, q_type b);
      logic [63:0] m;
      logic [63:0] mr;
      m = 64'(mag(a)) * 64'(mag(b));
      mr = (m + 64'(longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return mag_to_q(mr, a[W-1] ^ b[W-1]);
   endfunction

   // load a divider lane: numerator carries the rounding half divisor
   function automatic dv_lane_type dv_init(logic [W-1:0] ma, logic [W-1:0] d, logic neg);
      dv_lane_type o;
      logic [W-1:0] dd;
      dd = (d == '0) ? W'(1) : d;
      o.rem = '0;
      o.quo = '0;
      o.dvs = dd;
      o.neg = neg;
      o.num = {ma, {FRAC_BITS{1'b0}}} + NUM_W'(dd >> 1);
      return o;
   endfunction

   // one restoring quotient bit
   function automatic dv_lane_type dv_step(dv_lane_type l);
      dv_lane_type o;
      logic [W:0] t;
      o = l;
      t = {l.rem, l.num[NUM_W-1]};
      o.num = l.num << 1;
      if (t >= {1'b0, l.dvs}) begin
         o.rem = W'(t - {1'b0, l.dvs});
         o.quo = {l.quo[NUM_W-2:0], 1'b1};
      end else begin
         o.rem = t[W-1:0];
         o.quo = {l.quo[NUM_W-2:0], 1'b0};
      end
      return o;
   endfunction

   function automatic q_type dv_result(dv_lane_type l);
      return mag_to_q(64'(l.quo), l.neg);
   endfunction

endpackage

/* hw/rtl/pfsd_req_if.sv */
interface pfsd_req_if import pfsd_pkg::*; ();
   logic valid;
   logic ready;
   q_type normal_force;
   q_type shear_force_x;
   q_type shear_force_y;
   q_type pos_x;
   q_type pos_y;
   q_type pos_z;
   q_type disp_x_in;
   q_type disp_y_in;
   q_type disp_z_in;

   modport source (output valid, normal_force, shear_force_x, shear_force_y, pos_x, pos_y,
                   pos_z, disp_x_in, disp_y_in, disp_z_in, input ready);
   modport sink (input valid, normal_force, shear_force_x, shear_force_y, pos_x, pos_y,
                 pos_z, disp_x_in, disp_y_in, disp_z_in, output ready);
endinterface

/* hw/rtl/pfsd_rsp_if.sv */
interface pfsd_rsp_if import pfsd_pkg::*; ();
   logic valid;
   logic ready;
   q_type disp_x_out;
   q_type disp_y_out;
   q_type disp_z_out;
   logic singular;

   modport source (output valid, disp_x_out, disp_y_out, disp_z_out, singular, input ready);
   modport sink (input valid, disp_x_out, disp_y_out, disp_z_out, singular, output ready);
endinterface

/* hw/rtl/pfsd_sqrt_cell.sv */
module pfsd_sqrt_cell import pfsd_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic      clock,
   input  logic      en,
   input  sq_pl_type cell_in,
   output sq_pl_type cell_out
);
   localparam logic [63:0] BIT = 64'(1) << (62 - 2 * STEP);

   sq_pl_type pl_in;
   sq_pl_type pl_ff;

   // one root bit of the restoring square root
   always_comb begin
      pl_in = cell_in;
      if (cell_in.rem >= cell_in.root + BIT) begin
         pl_in.rem = cell_in.rem - (cell_in.root + BIT);
         pl_in.root = (cell_in.root >> 1) + BIT;
      end else begin
         pl_in.root = cell_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) pl_ff <= pl_in;
   end

   assign cell_out = pl_ff;
endmodule

/* hw/rtl/pfsd_div_cell.sv */
module pfsd_div_cell import pfsd_pkg::*; (
   input  logic      clock,
   input  logic      en,
   input  dv_pl_type cell_in,
   output dv_pl_type cell_out
);
   dv_pl_type pl_in;
   dv_pl_type pl_ff;

   // one quotient bit in every lane
   always_comb begin
      pl_in.side = cell_in.side;
      for (int i = 0; i < NUM_LANES; i++) begin
         pl_in.lane[i] = dv_step(cell_in.lane[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) pl_ff <= pl_in;
   end

   assign cell_out = pl_ff;
endmodule

/* hw/rtl/pfsd_terms.sv */
module pfsd_terms import pfsd_pkg::*; (
   input  logic                   clock,
   input  logic [TERM_STAGES-1:0] en,
   input  dv_pl_type              dv_in,
   input  q_type                  coef_a,
   input  q_type                  coef_b,
   output rsp_pl_type             rsp_out
);
   q_type cx, cy, zr, ir, irz, rr, fac;

   q_type czr_ff, cyzr_ff, xr_ff, yr_ff, cxy_ff, cxx_ff, cyy_ff, rrirz_ff, zz_ff, bir_ff;
   q_type ir1_ff, irz1_ff, fac1_ff;
   dv_side_type s1_ff;

   q_type xz_ff, yz_ff, axr_ff, ayr_ff, hxx_ff, hyy_ff, hxy_ff;
   q_type cxxir_ff, cyyir_ff, cxyir_ff, zzir_ff, bir2_ff, ir2_ff, irz2_ff, fac2_ff;
   dv_side_type s2_ff;

   q_type bpx_ff, bpy_ff, bpz_ff, bqxz_ff, bqyz_ff, ahxx_ff, ahyy_ff, ahxy_ff;
   q_type cxxir3_ff, cyyir3_ff, cxyir3_ff, ir3_ff, fac3_ff;
   dv_side_type s3_ff;

   q_type bpx4_ff, bpy4_ff, bpz4_ff, bqxz4_ff, bqyz4_ff, bqxx_ff, bqyy_ff, bqxy_ff, fac4_ff;
   dv_side_type s4_ff;

   q_type fpx_ff, fpy_ff, fpz_ff, fqxx_ff, fqyy_ff, fqxy_ff, fqxz_ff, fqyz_ff;
   dv_side_type s5_ff;

   q_type tx_p_ff, tx_qx_ff, tx_qy_ff, ty_p_ff, ty_qx_ff, ty_qy_ff;
   q_type tz_p_ff, tz_qx_ff, tz_qy_ff;
   dv_side_type s6_ff;

   rsp_pl_type out_ff;

   // quotients from the divider
   assign cx = dv_result(dv_in.lane[LANE_CX]);
   assign cy = dv_result(dv_in.lane[LANE_CY]);
   assign zr = dv_result(dv_in.lane[LANE_ZR]);
   assign ir = dv_result(dv_in.lane[LANE_IR]);
   assign irz = dv_result(dv_in.lane[LANE_IRZ]);
   assign rr = dv_result(dv_in.lane[LANE_RR]);
   assign fac = dv_result(dv_in.lane[LANE_FAC]);

   // first products
   always_ff @(posedge clock) begin
      if (en[0]) begin
         czr_ff <= qmul(cx, zr);
         cyzr_ff <= qmul(cy, zr);
         xr_ff <= qmul(cx, irz);
         yr_ff <= qmul(cy, irz);
         cxy_ff <= qmul(cx, cy);
         cxx_ff <= qmul(cx, cx);
         cyy_ff <= qmul(cy, cy);
         rrirz_ff <= qmul(rr, irz);
         zz_ff <= qmul(zr, zr);
         bir_ff <= qmul(coef_b, ir);
         ir1_ff <= ir;
         irz1_ff <= irz;
         fac1_ff <= fac;
         s1_ff <= dv_in.side;
      end
   end

   // second products
   always_ff @(posedge clock) begin
      if (en[1]) begin
         xz_ff <= qmul(czr_ff, ir1_ff);
         yz_ff <= qmul(cyzr_ff, ir1_ff);
         axr_ff <= qmul(coef_a, xr_ff);
         ayr_ff <= qmul(coef_a, yr_ff);
         hxx_ff <= qmul(cxx_ff, rrirz_ff);
         hyy_ff <= qmul(cyy_ff, rrirz_ff);
         hxy_ff <= qmul(cxy_ff, rrirz_ff);
         cxxir_ff <= qmul(cxx_ff, ir1_ff);
         cyyir_ff <= qmul(cyy_ff, ir1_ff);
         cxyir_ff <= qmul(cxy_ff, ir1_ff);
         zzir_ff <= qmul(zz_ff, ir1_ff);
         bir2_ff <= bir_ff;
         ir2_ff <= ir1_ff;
         irz2_ff <= irz1_ff;
         fac2_ff <= fac1_ff;
         s2_ff <= s1_ff;
      end
   end

   // brackets of the normal load, poisson parts of the tangential load
   always_ff @(posedge clock) begin
      if (en[2]) begin
         bpx_ff <= sat32(wq_type'(xz_ff) + wq_type'(axr_ff));
         bpy_ff <= sat32(wq_type'(yz_ff) + wq_type'(ayr_ff));
         bpz_ff <= sat32(wq_type'(zzir_ff) + wq_type'(bir2_ff));
         bqxz_ff <= sat32(wq_type'(xz_ff) - wq_type'(axr_ff));
         bqyz_ff <= sat32(wq_type'(yz_ff) - wq_type'(ayr_ff));
         ahxx_ff <= qmul(coef_a, sat32(wq_type'(irz2_ff) - wq_type'(hxx_ff)));
         ahyy_ff <= qmul(coef_a, sat32(wq_type'(irz2_ff) - wq_type'(hyy_ff)));
         ahxy_ff <= qmul(coef_a, hxy_ff);
         cxxir3_ff <= cxxir_ff;
         cyyir3_ff <= cyyir_ff;
         cxyir3_ff <= cxyir_ff;
         ir3_ff <= ir2_ff;
         fac3_ff <= fac2_ff;
         s3_ff <= s2_ff;
      end
   end

   // in-line and cross brackets of the tangential load
   always_ff @(posedge clock) begin
      if (en[3]) begin
         bqxx_ff <= sat32(wq_type'(ir3_ff) + wq_type'(cxxir3_ff) + wq_type'(ahxx_ff));
         bqyy_ff <= sat32(wq_type'(ir3_ff) + wq_type'(cyyir3_ff) + wq_type'(ahyy_ff));
         bqxy_ff <= sat32(wq_type'(cxyir3_ff) - wq_type'(ahxy_ff));
         bpx4_ff <= bpx_ff;
         bpy4_ff <= bpy_ff;
         bpz4_ff <= bpz_ff;
         bqxz4_ff <= bqxz_ff;
         bqyz4_ff <= bqyz_ff;
         fac4_ff <= fac3_ff;
         s4_ff <= s3_ff;
      end
   end

   // scale by the compliance prefactor
   always_ff @(posedge clock) begin
      if (en[4]) begin
         fpx_ff <= qmul(fac4_ff, bpx4_ff);
         fpy_ff <= qmul(fac4_ff, bpy4_ff);
         fpz_ff <= qmul(fac4_ff, bpz4_ff);
         fqxx_ff <= qmul(fac4_ff, bqxx_ff);
         fqyy_ff <= qmul(fac4_ff, bqyy_ff);
         fqxy_ff <= qmul(fac4_ff, bqxy_ff);
         fqxz_ff <= qmul(fac4_ff, bqxz4_ff);
         fqyz_ff <= qmul(fac4_ff, bqyz4_ff);
         s5_ff <= s4_ff;
      end
   end

   // apply the force components
   always_ff @(posedge clock) begin
      if (en[5]) begin
         tx_p_ff <= qmul(fpx_ff, s5_ff.normal_force);
         tx_qx_ff <= qmul(fqxx_ff, s5_ff.shear_force_x);
         tx_qy_ff <= qmul(fqxy_ff, s5_ff.shear_force_y);
         ty_p_ff <= qmul(fpy_ff, s5_ff.normal_force);
         ty_qx_ff <= qmul(fqxy_ff, s5_ff.shear_force_x);
         ty_qy_ff <= qmul(fqyy_ff, s5_ff.shear_force_y);
         tz_p_ff <= qmul(fpz_ff, s5_ff.normal_force);
         tz_qx_ff <= qmul(fqxz_ff, s5_ff.shear_force_x);
         tz_qy_ff <= qmul(fqyz_ff, s5_ff.shear_force_y);
         s6_ff <= s5_ff;
      end
   end

   // accumulate into the incoming displacement, or pass it on when singular
   always_ff @(posedge clock) begin
      if (en[6]) begin
         out_ff.singular <= s6_ff.singular;
         if (s6_ff.singular) begin
            out_ff.disp_x_out <= s6_ff.disp_x_in;
            out_ff.disp_y_out <= s6_ff.disp_y_in;
            out_ff.disp_z_out <= s6_ff.disp_z_in;
         end else begin
            out_ff.disp_x_out <= sat32(wq_type'(s6_ff.disp_x_in) + wq_type'(tx_p_ff)
                                       + wq_type'(tx_qx_ff) + wq_type'(tx_qy_ff));
            out_ff.disp_y_out <= sat32(wq_type'(s6_ff.disp_y_in) + wq_type'(ty_p_ff)
                                       + wq_type'(ty_qx_ff) + wq_type'(ty_qy_ff));
            out_ff.disp_z_out <= sat32(wq_type'(s6_ff.disp_z_in) + wq_type'(tz_p_ff)
                                       + wq_type'(tz_qx_ff) + wq_type'(tz_qy_ff));
         end
      end
   end

   assign rsp_out = out_ff;
endmodule

/* hw/rtl/point_force_surface_displacement.sv */
// pipeline: squares, 32 root cells, setup, 48 quotient cells, 7 product and sum stages
// throughput: one request per cycle unless the row is full and the output stalled; every
//   stage advances when it or a later stage has room, so bubbles close up under output stalls
// reset: synchronous, clears all stage valid bits and loads G = 1.0, nu = 0.3
module point_force_surface_displacement import pfsd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pfsd_req_if.sink          req_ch,
   pfsd_rsp_if.source        rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   logic [30:0] shear_ff;
   logic [15:0] poisson_ff;
   logic csr_wr;
   logic [30:0] g_eff;
   q_type coef_a, coef_b;

   logic [N_STG-1:0] valid_ff, valid_in, en;

   sq_pl_type sq_ff;
   sq_pl_type sq_link [0:SQRT_STEPS];
   dv_pl_type dv_ff;
   dv_pl_type dv_in;
   dv_pl_type dv_link [0:DIV_STEPS];
   rsp_pl_type rsp_pl;

   logic [31:0] root;
   logic signed [W+1:0] rzw;
   logic [W-1:0] r_s;
   q_type rz;

   // configuration registers
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shear_ff <= SHEAR_RESET;
         poisson_ff <= POISSON_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            CSR_IDX_SHEAR: shear_ff <= csr_pwdata[30:0];
            CSR_IDX_POISSON: poisson_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_SHEAR: csr_prdata = {1'b0, shear_ff};
         CSR_IDX_POISSON: csr_prdata = {16'b0, poisson_ff};
         default: csr_prdata = '0;
      endcase
   end

   // material coefficients, nu in Q0.16 has the internal fraction width
   assign g_eff = (shear_ff == '0) ? 31'd1 : shear_ff;
   assign coef_a = q_type'(ONE_QF) - q_type'({15'b0, poisson_ff, 1'b0});
   assign coef_b = q_type'(ONE_QF << 1) - q_type'({15'b0, poisson_ff, 1'b0});

   // stage enables: a stage moves when it, some later stage or the output has room
   always_comb begin
      for (int k = 0; k < N_STG; k++) begin
         en[k] = rsp_ch.ready | (|(~valid_ff & ({N_STG{1'b1}} << k)));
      end
      valid_in[0] = en[0] ? req_ch.valid : valid_ff[0];
      for (int k = 1; k < N_STG; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= valid_in;
   end

   assign req_ch.ready = en[0];
   assign rsp_ch.valid = valid_ff[N_STG-1];

   // planar radius squared
   always_ff @(posedge clock) begin
      if (en[0]) begin
         sq_ff.rem <= 64'(mag(req_ch.pos_x)) * 64'(mag(req_ch.pos_x))
                      + 64'(mag(req_ch.pos_y)) * 64'(mag(req_ch.pos_y));
         sq_ff.root <= '0;
         sq_ff.side.pos_x <= req_ch.pos_x;
         sq_ff.side.pos_y <= req_ch.pos_y;
         sq_ff.side.pos_z <= req_ch.pos_z;
         sq_ff.side.normal_force <= req_ch.normal_force;
         sq_ff.side.shear_force_x <= req_ch.shear_force_x;
         sq_ff.side.shear_force_y <= req_ch.shear_force_y;
         sq_ff.side.disp_x_in <= req_ch.disp_x_in;
         sq_ff.side.disp_y_in <= req_ch.disp_y_in;
         sq_ff.side.disp_z_in <= req_ch.disp_z_in;
      end
   end

   // square root cells
   assign sq_link[0] = sq_ff;
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      pfsd_sqrt_cell #(.STEP(k)) u_cell (
         .clock    (clock),
         .en       (en[1+k]),
         .cell_in  (sq_link[k]),
         .cell_out (sq_link[k+1])
      );
   end

   // singular test and divider setup
   assign root = sq_link[SQRT_STEPS].root[31:0];
   assign rzw = (W+2)'($signed({2'b0, root})) - (W+2)'(sq_link[SQRT_STEPS].side.pos_z);
   assign r_s = root[31] ? 32'h7fff_ffff : root;
   assign rz = sat32(WW'(rzw));

   always_comb begin
      dv_in.side.normal_force = sq_link[SQRT_STEPS].side.normal_force;
      dv_in.side.shear_force_x = sq_link[SQRT_STEPS].side.shear_force_x;
      dv_in.side.shear_force_y = sq_link[SQRT_STEPS].side.shear_force_y;
      dv_in.side.disp_x_in = sq_link[SQRT_STEPS].side.disp_x_in;
      dv_in.side.disp_y_in = sq_link[SQRT_STEPS].side.disp_y_in;
      dv_in.side.disp_z_in = sq_link[SQRT_STEPS].side.disp_z_in;
      dv_in.side.singular = (root == '0) || (rzw == '0);
      dv_in.lane[LANE_CX] = dv_init(mag(sq_link[SQRT_STEPS].side.pos_x), r_s,
                                    sq_link[SQRT_STEPS].side.pos_x[W-1]);
      dv_in.lane[LANE_CY] = dv_init(mag(sq_link[SQRT_STEPS].side.pos_y), r_s,
                                    sq_link[SQRT_STEPS].side.pos_y[W-1]);
      dv_in.lane[LANE_ZR] = dv_init(mag(sq_link[SQRT_STEPS].side.pos_z), r_s,
                                    sq_link[SQRT_STEPS].side.pos_z[W-1]);
      dv_in.lane[LANE_IR] = dv_init(ONE_QF, r_s, 1'b0);
      dv_in.lane[LANE_IRZ] = dv_init(ONE_QF, mag(rz), rz[W-1]);
      dv_in.lane[LANE_RR] = dv_init(r_s, mag(rz), rz[W-1]);
      dv_in.lane[LANE_FAC] = dv_init(INV4PI_QF, {1'b0, g_eff}, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (en[ST_PREP]) dv_ff <= dv_in;
   end

   // quotient cells
   assign dv_link[0] = dv_ff;
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      pfsd_div_cell u_cell (
         .clock    (clock),
         .en       (en[ST_PREP+1+k]),
         .cell_in  (dv_link[k]),
         .cell_out (dv_link[k+1])
      );
   end

   // products, brackets and accumulation
   pfsd_terms u_terms (
      .clock   (clock),
      .en      (en[N_STG-1 -: TERM_STAGES]),
      .dv_in   (dv_link[DIV_STEPS]),
      .coef_a  (coef_a),
      .coef_b  (coef_b),
      .rsp_out (rsp_pl)
   );

   assign rsp_ch.disp_x_out = rsp_pl.disp_x_out;
   assign rsp_ch.disp_y_out = rsp_pl.disp_y_out;
   assign rsp_ch.disp_z_out = rsp_pl.disp_z_out;
   assign rsp_ch.singular = rsp_pl.singular;

   // a full row with a stalled output takes no request
   assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken into a full pipeline");

   // an empty output stage never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !valid_ff[N_STG-1] |-> req_ch.ready)
      else $error("input blocked with output stage empty");

   // a lone request raises occupancy by one
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && !(rsp_ch.valid && rsp_ch.ready))
      |=> ($countones(valid_ff) == $past($countones(valid_ff)) + 1))
      else $error("request lost or duplicated in pipeline");

   // shear modulus write lands
   assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[2] == CSR_IDX_SHEAR) |=> (shear_ff == $past(csr_pwdata[30:0])))
      else $error("shear modulus write not taken");
endmodule
